@@ src/cidec_pkg.sv @@
`timescale 1ns / 1ps

package cidec_pkg;

    localparam int unsigned MAG_W   = 31;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 3;

    localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
    localparam logic [POS_W-1:0] POS_LAST  = 3'd4;
    localparam logic [6:0]       LAST_VALUE_MAX = 7'h0f;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                emit;
        logic [VALUE_W-1:0]  value;
        t_status             status;
        logic [MAG_W-1:0]    acc;
        logic [POS_W-1:0]    pos;
        logic                sign;
    } t_step;

endpackage

@@ src/cidec_step.sv @@
`timescale 1ns / 1ps

module cidec_step
    import cidec_pkg::*;
(
    input  logic [7:0]       i_data_byte,
    input  logic [MAG_W-1:0] i_acc,
    input  logic [POS_W-1:0] i_pos,
    input  logic             i_sign,
    output t_step            o_step
);

    logic [6:0]       payload;
    logic [MAG_W-1:0] acc_new;
    logic             sign_new;
    logic [VALUE_W-1:0] mag_ext;

    assign payload = i_data_byte[6:0];

    always_comb begin
        o_step   = '0;
        acc_new  = i_acc;
        sign_new = i_sign;
        o_step.status = STATUS_OK;
        if (i_pos == POS_FIRST) begin
            sign_new = i_data_byte[7];
            acc_new  = {25'b0, i_data_byte[5:0]};
            if (i_data_byte[6]) begin
                o_step.pos = 3'd1;
            end else begin
                o_step.emit = 1'b1;
            end
        end else if (i_pos inside {[3'd4:3'd7]}) begin
            if (payload > LAST_VALUE_MAX) begin
                o_step.emit   = 1'b1;
                o_step.status = STATUS_OVERFLOW;
            end else if (i_data_byte[7]) begin
                o_step.emit   = 1'b1;
                o_step.status = STATUS_TOO_LONG;
            end else begin
                acc_new     = i_acc | {payload[3:0], 27'b0};
                o_step.emit = 1'b1;
            end
        end else begin
            case (i_pos)
                3'd1:    acc_new = i_acc | {18'b0, payload, 6'b0};
                3'd2:    acc_new = i_acc | {11'b0, payload, 13'b0};
                3'd3:    acc_new = i_acc | {4'b0, payload, 20'b0};
                default: acc_new = i_acc;
            endcase
            if (i_data_byte[7]) begin
                o_step.pos = i_pos + 3'd1;
            end else begin
                o_step.emit = 1'b1;
            end
        end

        mag_ext = {1'b0, acc_new};
        if (o_step.emit) begin
            if (o_step.status == STATUS_OK) begin
                o_step.value = sign_new ? (VALUE_W'(0) - mag_ext) : mag_ext;
            end
        end else begin
            o_step.acc  = acc_new;
            o_step.sign = sign_new;
        end
    end

endmodule

@@ src/compact_index_decoder_core.sv @@
`timescale 1ns / 1ps
// A byte that ends a code shows its result in the cycle after it is accepted.
// Throughput: one byte per cycle while o_ready is high; the decode state updates for each accepted byte.
// A result waits in the output register; a new byte is accepted whenever that register
// is empty or is being read in the same cycle.
// Reset is synchronous and active low; it clears the decode state and the output valid.

module compact_index_decoder_core
    import cidec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_data_byte,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_decoded_value,
    output logic [1:0]                o_status
);

    logic [MAG_W-1:0]   r_acc;
    logic [POS_W-1:0]   r_pos;
    logic               r_sign;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value;
    t_status            r_status;
    t_step              step;
    logic               in_acc;

    cidec_step u_step (
        .i_data_byte (i_data_byte),
        .i_acc       (r_acc),
        .i_pos       (r_pos),
        .i_sign      (r_sign),
        .o_step      (step)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pos       <= POS_FIRST;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_acc  <= step.acc;
                r_pos  <= step.pos;
                r_sign <= step.sign;
            end
            if (in_acc && step.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && step.emit) begin
            r_value  <= step.value;
            r_status <= step.status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_decoded_value = r_value;
    assign o_status        = r_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STATUS_OK) |-> (r_value == '0))
        else $error("Error result carries a nonzero value.");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_LAST))
        else $error("Byte position left its range.");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && step.emit) |=> r_out_valid)
        else $error("Finished code did not raise output valid.");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && step.emit) |=> (r_pos == POS_FIRST))
        else $error("Decoder did not return to the first byte after a result.");

endmodule
